@@ rtl/lifc_pkg.sv @@
// Shared constants, control-word types and arithmetic helpers for the conductance LIF neuron.
package lifc_pkg;

	localparam int FRACTION_BITS_DEF = 15;
	localparam int DATA_W            = 32;
	localparam int PROD_W            = 2 * DATA_W;
	localparam int COUNT_W           = 16;
	localparam int DECAY_W           = 16;
	localparam int CFG_IDX_W         = 3;
	localparam int STEP_W            = 4;
	localparam int IN_W              = 3 * DATA_W;
	localparam int OUT_USER_W        = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [STEP_W-1:0]    step_t;

	localparam cfg_idx_t REG_THRESHOLD  = 3'd0;
	localparam cfg_idx_t REG_RESET_V    = 3'd1;
	localparam cfg_idx_t REG_REST_V     = 3'd2;
	localparam cfg_idx_t REG_EXC_REV    = 3'd3;
	localparam cfg_idx_t REG_INH_REV    = 3'd4;
	localparam cfg_idx_t REG_RESISTANCE = 3'd5;
	localparam cfg_idx_t REG_DECAY      = 3'd6;
	localparam cfg_idx_t REG_REFR_STEPS = 3'd7;

	typedef enum logic [1:0] {ADD_A_ER, ADD_A_IR, ADD_A_ACC, ADD_A_P} add_a_t;
	typedef enum logic [2:0] {ADD_B_V, ADD_B_P, ADD_B_BIAS, ADD_B_REST, ADD_B_ZERO} add_b_t;
	typedef enum logic [1:0] {DST_NONE, DST_T, DST_ACC} add_dst_t;
	typedef enum logic [1:0] {MUL_A_GE, MUL_A_GI, MUL_A_ACC, MUL_A_DECAY} mul_a_t;
	typedef enum logic {MUL_B_T, MUL_B_RES} mul_b_t;
	typedef enum logic [1:0] {FIN_NONE, FIN_UPDATE, FIN_SKIP} fin_t;

	typedef struct packed {
		add_a_t   add_a;
		add_b_t   add_b;
		logic     add_sub;
		add_dst_t add_dst;
		logic     mul_en;
		mul_a_t   mul_a;
		mul_b_t   mul_b;
		logic     jump_refr;
		step_t    target;
		fin_t     fin;
	} ctrl_t;

	localparam step_t STEP_SKIP = 4'd10;

	// microprogram: one control word per step
	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		c = '0;
		unique case (s)
			4'd0: begin
				c.add_a = ADD_A_ER;  c.add_b = ADD_B_V;    c.add_sub = 1'b1; c.add_dst = DST_T;
				c.jump_refr = 1'b1;  c.target = STEP_SKIP;
			end
			4'd1: begin
				c.mul_en = 1'b1;     c.mul_a = MUL_A_GE;   c.mul_b = MUL_B_T;
				c.add_a = ADD_A_IR;  c.add_b = ADD_B_V;    c.add_sub = 1'b1; c.add_dst = DST_T;
			end
			4'd2: begin
				c.mul_en = 1'b1;     c.mul_a = MUL_A_GI;   c.mul_b = MUL_B_T;
				c.add_a = ADD_A_P;   c.add_b = ADD_B_ZERO; c.add_dst = DST_ACC;
			end
			4'd3: begin
				c.add_a = ADD_A_ACC; c.add_b = ADD_B_P;    c.add_dst = DST_ACC;
			end
			4'd4: begin
				c.add_a = ADD_A_ACC; c.add_b = ADD_B_BIAS; c.add_dst = DST_ACC;
			end
			4'd5: begin
				c.mul_en = 1'b1;     c.mul_a = MUL_A_ACC;  c.mul_b = MUL_B_RES;
			end
			4'd6: begin
				c.add_a = ADD_A_P;   c.add_b = ADD_B_REST; c.add_dst = DST_ACC;
			end
			4'd7: begin
				c.add_a = ADD_A_ACC; c.add_b = ADD_B_V;    c.add_sub = 1'b1; c.add_dst = DST_T;
			end
			4'd8: begin
				c.mul_en = 1'b1;     c.mul_a = MUL_A_DECAY; c.mul_b = MUL_B_T;
			end
			4'd9: begin
				c.add_a = ADD_A_ACC; c.add_b = ADD_B_P;    c.add_sub = 1'b1;
				c.fin = FIN_UPDATE;
			end
			STEP_SKIP: begin
				c.fin = FIN_SKIP;
			end
			default: begin
				c.fin = FIN_SKIP;
			end
		endcase
		return c;
	endfunction

	function automatic logic [DATA_W-1:0] sat_sum(logic signed [DATA_W:0] x);
		logic [DATA_W-1:0] r;
		if (x[DATA_W] == x[DATA_W-1])
			r = x[DATA_W-1:0];
		else
			r = x[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] sat_prod(logic signed [PROD_W-1:0] x);
		logic [DATA_W-1:0] r;
		if (x[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){x[PROD_W-1]}})
			r = x[DATA_W-1:0];
		else
			r = x[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		return r;
	endfunction

endpackage

@@ rtl/lif_conductance_neuron_step.sv @@
// Conductance-based leaky integrate-and-fire neuron, one timestep per item.
// Input stream s_*: one item is one timestep carrying the excitatory and inhibitory
// conductances and the bias current (offset already added), all signed fixed point.
// Output stream m_*: one item per input, the membrane voltage after the step in
// m_tdata, the spike flag and the refractory-skip flag in m_tuser.
// Configuration port cfg_*: register index and data, always ready; write while idle.
// A microcoded sequencer drives one shared multiplier and one saturating adder:
// an active timestep runs the full microprogram from acceptance to a registered result
// (four dependent products plus the sums between them), a refractory timestep
// jumps from the first step to the skip step. The next item is accepted the cycle
// after a result is registered, so an item is not taken before the last one is done.
// While a finished result waits for m_tready, the next item is still accepted and
// computed; only its final step holds until the output register frees.
// Reset clears the membrane voltage, the refractory count and all configuration
// registers to zero and empties the output register.
module lif_conductance_neuron_step #(
	parameter int FRACTION_BITS = lifc_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [31:0] excitatory_conductance, [63:32] inhibitory_conductance, [95:64] bias_current
	input  logic [lifc_pkg::IN_W-1:0]            s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [31:0] membrane_out
	output logic [lifc_pkg::DATA_W-1:0]          m_tdata,
	// [0] spiked, [1] in_refractory
	output logic [lifc_pkg::OUT_USER_W-1:0]      m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  lifc_pkg::cfg_idx_t                   cfg_index,
	input  logic [lifc_pkg::DATA_W-1:0]          cfg_data
);

	localparam int W  = lifc_pkg::DATA_W;
	localparam int PW = lifc_pkg::PROD_W;

	logic [W-1:0]                     thr_q, reset_v_q, rest_q, exc_rev_q, inh_rev_q, res_q;
	logic [lifc_pkg::DECAY_W-1:0]     decay_q;
	logic [lifc_pkg::COUNT_W-1:0]     refr_steps_q;

	logic [W-1:0]                     v_q;
	logic [lifc_pkg::COUNT_W-1:0]     cnt_q;

	logic                             busy_q;
	lifc_pkg::step_t                  step_q;
	logic [W-1:0]                     ge_q, gi_q, bias_q;
	logic [W-1:0]                     t_q, acc_q;
	logic signed [PW-1:0]             p_q;

	logic                             out_valid_q;
	logic [W-1:0]                     out_v_q;
	logic                             out_spike_q, out_refr_q;

	lifc_pkg::ctrl_t                  ctrl;
	logic                             stall, run, s_accept, refr_active, spike;
	logic [W-1:0]                     add_a, add_b, add_res, p_sat, mul_a, mul_b;
	logic signed [W:0]                sum;
	logic signed [PW-1:0]             p_shift;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q;
	assign s_accept  = s_tvalid && !busy_q;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_v_q;
	assign m_tuser   = {out_refr_q, out_spike_q};

	assign ctrl        = lifc_pkg::ucode(step_q);
	assign stall       = (ctrl.fin != lifc_pkg::FIN_NONE) && out_valid_q && !m_tready;
	assign run         = busy_q && !stall;
	assign refr_active = (cnt_q != '0);

	assign p_shift = p_q >>> FRACTION_BITS;
	assign p_sat   = lifc_pkg::sat_prod(p_shift);

	always_comb begin
		unique case (ctrl.add_a)
			lifc_pkg::ADD_A_ER:  add_a = exc_rev_q;
			lifc_pkg::ADD_A_IR:  add_a = inh_rev_q;
			lifc_pkg::ADD_A_ACC: add_a = acc_q;
			lifc_pkg::ADD_A_P:   add_a = p_sat;
			default:             add_a = acc_q;
		endcase
		unique case (ctrl.add_b)
			lifc_pkg::ADD_B_V:    add_b = v_q;
			lifc_pkg::ADD_B_P:    add_b = p_sat;
			lifc_pkg::ADD_B_BIAS: add_b = bias_q;
			lifc_pkg::ADD_B_REST: add_b = rest_q;
			lifc_pkg::ADD_B_ZERO: add_b = '0;
			default:              add_b = '0;
		endcase
		if (ctrl.add_sub)
			sum = $signed({add_a[W-1], add_a}) - $signed({add_b[W-1], add_b});
		else
			sum = $signed({add_a[W-1], add_a}) + $signed({add_b[W-1], add_b});
		add_res = lifc_pkg::sat_sum(sum);
		spike   = $signed(add_res) >= $signed(thr_q);
	end

	always_comb begin
		unique case (ctrl.mul_a)
			lifc_pkg::MUL_A_GE:    mul_a = ge_q;
			lifc_pkg::MUL_A_GI:    mul_a = gi_q;
			lifc_pkg::MUL_A_ACC:   mul_a = acc_q;
			lifc_pkg::MUL_A_DECAY: mul_a = {{(W-lifc_pkg::DECAY_W){1'b0}}, decay_q};
			default:               mul_a = acc_q;
		endcase
		unique case (ctrl.mul_b)
			lifc_pkg::MUL_B_T:   mul_b = t_q;
			lifc_pkg::MUL_B_RES: mul_b = res_q;
			default:             mul_b = t_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= '0;
			reset_v_q    <= '0;
			rest_q       <= '0;
			exc_rev_q    <= '0;
			inh_rev_q    <= '0;
			res_q        <= '0;
			decay_q      <= '0;
			refr_steps_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lifc_pkg::REG_THRESHOLD:  thr_q        <= cfg_data;
				lifc_pkg::REG_RESET_V:    reset_v_q    <= cfg_data;
				lifc_pkg::REG_REST_V:     rest_q       <= cfg_data;
				lifc_pkg::REG_EXC_REV:    exc_rev_q    <= cfg_data;
				lifc_pkg::REG_INH_REV:    inh_rev_q    <= cfg_data;
				lifc_pkg::REG_RESISTANCE: res_q        <= cfg_data;
				lifc_pkg::REG_DECAY:      decay_q      <= cfg_data[lifc_pkg::DECAY_W-1:0];
				lifc_pkg::REG_REFR_STEPS: refr_steps_q <= cfg_data[lifc_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			v_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (run && (ctrl.fin != lifc_pkg::FIN_NONE))
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			if (s_accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (run) begin
				if (ctrl.fin != lifc_pkg::FIN_NONE) begin
					busy_q      <= 1'b0;
					step_q      <= '0;
					if (ctrl.fin == lifc_pkg::FIN_UPDATE) begin
						v_q <= spike ? reset_v_q : add_res;
						if (spike)
							cnt_q <= refr_steps_q;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end else if (ctrl.jump_refr && refr_active) begin
					step_q <= ctrl.target;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			ge_q   <= s_tdata[W-1:0];
			gi_q   <= s_tdata[2*W-1:W];
			bias_q <= s_tdata[3*W-1:2*W];
		end
		if (run) begin
			if (ctrl.add_dst == lifc_pkg::DST_T)
				t_q <= add_res;
			if (ctrl.add_dst == lifc_pkg::DST_ACC)
				acc_q <= add_res;
			if (ctrl.mul_en)
				p_q <= $signed(mul_a) * $signed(mul_b);
			if (ctrl.fin == lifc_pkg::FIN_UPDATE) begin
				out_v_q     <= spike ? reset_v_q : add_res;
				out_spike_q <= spike;
				out_refr_q  <= 1'b0;
			end else if (ctrl.fin == lifc_pkg::FIN_SKIP) begin
				out_v_q     <= v_q;
				out_spike_q <= 1'b0;
				out_refr_q  <= 1'b1;
			end
		end
	end

endmodule
